FILE: hw/rtl/hkct_pkg.sv
// Shared types, constants and helper functions for the hashed key counter table.
// Used by the controller, the datapath and the top level; depends on nothing else.
package hkct_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // Operation codes carried in the req_type field.
   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_DELETE = 3'd1,
      OP_UPDATE = 3'd2,
      OP_RESET  = 3'd3,
      OP_GET    = 3'd4
   } req_op_type;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // Counter width codes.
   localparam logic [1:0] CW_8  = 2'd0;
   localparam logic [1:0] CW_16 = 2'd1;
   localparam logic [1:0] CW_32 = 2'd2;

   // Request and response words.
   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  key_byte;
      logic        key_last;
      logic [1:0]  counter_width;
      logic [63:0] update_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] read_value;
   } rsp_word_type;

   // One step of the hash sequence, selected by the controller.
   typedef enum logic [2:0] {
      HASH_HOLD,
      HASH_ADD_BYTE,
      HASH_MIX_BYTE,
      HASH_FIN_3,
      HASH_FIN_11,
      HASH_FIN_15
   } hash_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      hash_op_type hash_op;
      logic        scan_start;
      logic        scan_step;
      logic        execute;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic scan_end;
      logic rsp_busy;
   } dp_status_type;

   // Mask that keeps the bits of a counter of the given width code.
   function automatic logic [63:0] width_mask(input logic [1:0] cw);
      logic [63:0] m;
      case (cw)
         CW_8:    m = 64'h0000_0000_0000_00FF;
         CW_16:   m = 64'h0000_0000_0000_FFFF;
         CW_32:   m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/hkct_ctrl.sv
// Sequencing controller for the hashed key counter table.
// Depends on hkct_pkg; drives commands into hkct_datapath.
module hkct_ctrl
   import hkct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD_ADD,
      ST_FOLD_MIX,
      ST_FIN_3,
      ST_FIN_11,
      ST_FIN_15,
      ST_SCAN,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_FOLD_ADD;
         ST_FOLD_ADD: state_in = ST_FOLD_MIX;
         ST_FOLD_MIX: state_in = dp_status.last ? ST_FIN_3 : ST_IDLE;
         ST_FIN_3:    state_in = ST_FIN_11;
         ST_FIN_11:   state_in = ST_FIN_15;
         ST_FIN_15:   state_in = ST_SCAN;
         ST_SCAN:     if (dp_status.scan_end) state_in = ST_EXEC;
         ST_EXEC:     if (!dp_status.rsp_busy) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands decoded from the current state.
   always_comb begin
      dp_cmd         = '0;
      dp_cmd.hash_op = HASH_HOLD;
      case (state_ff)
         ST_IDLE:     dp_cmd.load = req_valid;
         ST_FOLD_ADD: dp_cmd.hash_op = HASH_ADD_BYTE;
         ST_FOLD_MIX: dp_cmd.hash_op = HASH_MIX_BYTE;
         ST_FIN_3:    dp_cmd.hash_op = HASH_FIN_3;
         ST_FIN_11:   dp_cmd.hash_op = HASH_FIN_11;
         ST_FIN_15: begin
            dp_cmd.hash_op    = HASH_FIN_15;
            dp_cmd.scan_start = 1'b1;
         end
         ST_SCAN:     dp_cmd.scan_step = 1'b1;
         ST_EXEC:     dp_cmd.execute = !dp_status.rsp_busy;
         default:     dp_cmd.hash_op = HASH_HOLD;
      endcase
   end

   // A new word is taken only while nothing is in progress.
   assign req_stall = (state_ff != ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/hkct_datapath.sv
// Datapath of the hashed key counter table: hash register, counter table,
// search registers and the response register. Depends on hkct_pkg.
module hkct_datapath
   import hkct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word
);

   // Captured request word.
   req_word_type item_ff;

   // Hash state and finished key.
   logic [63:0] hash_ff;
   logic [63:0] key_ff;

   // Counter table; only the valid bits are reset.
   logic              valid_ff [TABLE_ENTRIES];
   logic [63:0]       tkey_ff  [TABLE_ENTRIES];
   logic [1:0]        twidth_ff[TABLE_ENTRIES];
   logic [63:0]       tvalue_ff[TABLE_ENTRIES];

   // Search registers.
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   // Response register and the word it takes on execute.
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      rsp_word_in;

   logic [63:0]       byte_sext;
   logic [63:0]       mix_sum;
   logic [63:0]       hit_value;
   logic [1:0]        hit_width;
   logic [63:0]       hit_mask;
   logic              scan_match;
   logic              scan_free;
   req_op_type        op;

   assign byte_sext = {{56{item_ff.key_byte[7]}}, item_ff.key_byte};
   assign mix_sum   = hash_ff + (hash_ff << 10);
   assign hit_value = tvalue_ff[hit_idx_ff];
   assign hit_width = twidth_ff[hit_idx_ff];
   assign hit_mask  = width_mask(hit_width);
   assign op        = req_op_type'(item_ff.req_type);

   assign scan_match = valid_ff[scan_idx_ff] && (tkey_ff[scan_idx_ff] == key_ff);
   assign scan_free  = !valid_ff[scan_idx_ff];

   assign dp_status.last     = item_ff.key_last;
   assign dp_status.scan_end = (scan_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign dp_status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Request capture.
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         item_ff <= req_word;
      end
   end

   // Hash steps: one per cycle, each a wide add, a xor, or for the mix both.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         case (dp_cmd.hash_op)
            HASH_ADD_BYTE: hash_ff <= hash_ff + byte_sext;
            HASH_MIX_BYTE: hash_ff <= mix_sum ^ (mix_sum >> 6);
            HASH_FIN_3:    hash_ff <= hash_ff + (hash_ff << 3);
            HASH_FIN_11:   hash_ff <= hash_ff ^ (hash_ff >> 11);
            HASH_FIN_15:   hash_ff <= '0;
            default:       hash_ff <= hash_ff;
         endcase
      end
   end

   // The last finishing step lands in the key register.
   always_ff @(posedge clock) begin
      if (dp_cmd.hash_op == HASH_FIN_15) begin
         key_ff <= hash_ff + (hash_ff << 15);
      end
   end

   // Search walks one entry per cycle, keeping the first match and first free slot.
   always_ff @(posedge clock) begin
      if (dp_cmd.scan_start) begin
         scan_idx_ff <= '0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else if (dp_cmd.scan_step) begin
         if (!dp_status.scan_end) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (scan_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= scan_idx_ff;
         end
         if (scan_free && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= scan_idx_ff;
         end
      end
   end

   // Valid bits: set on a successful add, cleared on delete.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (dp_cmd.execute) begin
         if (op == OP_ADD && !hit_ff && free_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end else if (op == OP_DELETE && hit_ff) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end
      end
   end

   // Entry payload writes.
   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         case (op)
            OP_ADD: begin
               if (!hit_ff && free_ff) begin
                  tkey_ff[free_idx_ff]   <= key_ff;
                  twidth_ff[free_idx_ff] <= item_ff.counter_width;
                  tvalue_ff[free_idx_ff] <= '0;
               end
            end
            OP_UPDATE: begin
               if (hit_ff) begin
                  tvalue_ff[hit_idx_ff] <= (hit_value + item_ff.update_value) & hit_mask;
               end
            end
            OP_RESET: begin
               if (hit_ff) begin
                  tvalue_ff[hit_idx_ff] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Response register: loaded on execute, emptied when the word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Status and read value for the operation being executed.
   always_comb begin
      rsp_word_in.status     = STATUS_OK;
      rsp_word_in.read_value = '0;
      case (op)
         OP_ADD: begin
            if (!hit_ff && !free_ff) begin
               rsp_word_in.status = STATUS_FULL;
            end
         end
         OP_DELETE, OP_UPDATE, OP_RESET: begin
            if (!hit_ff) begin
               rsp_word_in.status = STATUS_NOT_FOUND;
            end
         end
         OP_GET: begin
            if (hit_ff) begin
               rsp_word_in.read_value = hit_value & hit_mask;
            end else begin
               rsp_word_in.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

FILE: hw/rtl/hashed_key_counter_table_top.sv
// Top level of the hashed key counter table: joins controller and datapath.
// Depends on hkct_pkg, hkct_ctrl and hkct_datapath.
//
// Counter names arrive one byte per request word and are folded into a 64-bit
// one-at-a-time hash. A byte that is not the last is captured and takes two
// hash steps, and gives no response. The last byte also finishes the hash in
// three steps, then searches the table one entry per cycle and runs the
// operation. Exactly one response word follows each last byte; it is held in
// an output register, so the next name may start while it waits. Entries are
// matched on the hash alone.
module hashed_key_counter_table_top
   import hkct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   hkct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Hash, table and response datapath.
   hkct_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
